// File: sv/sipf_pkg.sv
// ============================================================================
// sipf_pkg - shared types and constants for the SI prefix formatter
// Beat structs for both channels, the job record passed from the front end
// to the character sequencer, and the ASCII codes that are emitted.
// ============================================================================
package sipf_pkg;

    // Decimal digit positions of a 32-bit value
    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
    localparam int unsigned BIN_W      = 32;
    localparam int unsigned BITS_PER_STEP = 4;
    localparam int unsigned CONV_STEPS    = BIN_W / BITS_PER_STEP;

    // Exponents at which a thousands group ends
    localparam logic [3:0] EXP_GIGA = 4'd9;
    localparam logic [3:0] EXP_MEGA = 4'd6;
    localparam logic [3:0] EXP_KILO = 4'd3;

    // ASCII codes
    localparam logic [7:0] ASC_ZERO  = 8'h30;
    localparam logic [7:0] ASC_POINT = 8'h2E;
    localparam logic [7:0] ASC_G     = 8'h47;
    localparam logic [7:0] ASC_M     = 8'h4D;
    localparam logic [7:0] ASC_K     = 8'h6B;
    localparam logic [7:0] ASC_MILLI = 8'h6D;
    localparam logic [7:0] ASC_MICRO = 8'h75;

    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  frac_digits;
        logic        scale_sign;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_out_beat;

    // One classified number, ready to be spelt out
    typedef struct packed {
        logic [NUM_DIGITS-1:0][3:0] digits;   // BCD, index = decimal exponent
        logic [3:0]                 top;      // first digit position
        logic [3:0]                 stop;     // last digit position
        logic                       has_pnt;
        logic [3:0]                 pnt_pos;  // point follows this position
        logic                       has_unit;
        logic [7:0]                 unit_ch;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: sv/sipf_front.sv
// ============================================================================
// sipf_front - binary to BCD conversion and classification
// Double-dabble, four bits a cycle, then a push state that finds the leading
// digit, the thousands group, the point and the suffix, and queues the job.
// ============================================================================
module sipf_front
    import sipf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_in_beat i_item,
    input  t_q_stat  i_q_stat,
    output logic     o_push,
    output t_job     o_job
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate            r_state, n_state;
    logic [2:0]         r_cnt;
    logic [BIN_W-1:0]   r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [3:0]         r_frac;
    logic               r_sign;

    logic [BCD_W-1:0]   bcd_nx;
    logic               accept;

    // add-3 correction on every digit, then shift one bit in
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b,
                                                 input logic bit_in);
        logic [BCD_W-1:0] t;
        t = b;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (t[k*4 +: 4] >= 4'd5) begin
                t[k*4 +: 4] = t[k*4 +: 4] + 4'd3;
            end
        end
        return {t[BCD_W-2:0], bit_in};
    endfunction

    always_comb begin
        bcd_nx = r_bcd;
        for (int j = 0; j < BITS_PER_STEP; j++) begin
            bcd_nx = dd_step(bcd_nx, r_bin[BIN_W-1-j]);
        end
    end

    assign busy   = !((r_state == F_IDLE) || ((r_state == F_PUSH) && !i_q_stat.full));
    assign accept = start && !busy;
    assign o_push = (r_state == F_PUSH) && !i_q_stat.full;

    // classification of the finished conversion
    logic [3:0] top, grp, fr, eff;
    logic       has_grp;

    always_comb begin
        o_job        = '0;
        o_job.digits = r_bcd;
        top = 4'd0;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (r_bcd[k*4 +: 4] != 4'd0) begin
                top = 4'(k);
            end
        end
        has_grp = 1'b1;
        if (top >= EXP_GIGA) begin
            grp = EXP_GIGA;
        end else if (top >= EXP_MEGA) begin
            grp = EXP_MEGA;
        end else if (top >= EXP_KILO) begin
            grp = EXP_KILO;
        end else begin
            grp     = 4'd0;
            has_grp = 1'b0;
        end
        // single leading digit with no fraction asked: show one anyway
        fr  = ((r_frac == 4'd0) && (top == grp)) ? 4'd1 : r_frac;
        eff = (fr > grp) ? grp : fr;

        o_job.top     = top;
        o_job.pnt_pos = grp;
        o_job.has_pnt = has_grp && (eff != 4'd0);
        o_job.stop    = has_grp ? (grp - eff) : 4'd0;
        o_job.has_unit = 1'b0;
        o_job.unit_ch  = ASC_G;
        if (has_grp) begin
            case (grp)
                EXP_GIGA: begin
                    o_job.has_unit = !r_sign;
                    o_job.unit_ch  = ASC_G;
                end
                EXP_MEGA: begin
                    o_job.has_unit = 1'b1;
                    o_job.unit_ch  = r_sign ? ASC_MILLI : ASC_M;
                end
                default: begin
                    o_job.has_unit = 1'b1;
                    o_job.unit_ch  = r_sign ? ASC_MICRO : ASC_K;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept) n_state = F_CONV;
            end
            F_CONV: begin
                if (r_cnt == 3'(CONV_STEPS - 1)) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (accept) begin
                    n_state = F_CONV;
                end else if (o_push) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= 3'd0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= 3'd0;
            end else if (r_state == F_CONV) begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bin  <= i_item.value;
            r_bcd  <= '0;
            r_frac <= i_item.frac_digits;
            r_sign <= i_item.scale_sign;
        end else if (r_state == F_CONV) begin
            r_bin <= {r_bin[BIN_W-1-BITS_PER_STEP:0], {BITS_PER_STEP{1'b0}}};
            r_bcd <= bcd_nx;
        end
    end

endmodule

// File: sv/sipf_queue.sv
// ============================================================================
// sipf_queue - two-entry job queue
// Decouples the converter from the character sequencer.
// ============================================================================
module sipf_queue
    import sipf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= !r_wr;
            if (do_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_job;
    end

endmodule

// File: sv/sipf_back.sv
// ============================================================================
// sipf_back - character sequencer
// Walks one job's digits, point and suffix, one character a cycle, through
// a registered output.
// ============================================================================
module sipf_back
    import sipf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    output logic      o_strobe,
    output t_out_beat o_result
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIGIT = 4'b0010,
        S_POINT = 4'b0100,
        S_UNIT  = 4'b1000
    } t_bstate;

    t_bstate    r_state, n_state;
    t_job       r_job, n_job;
    logic [3:0] r_pos, n_pos;
    logic       r_strobe, n_strobe;
    t_out_beat  r_out, n_out;
    logic       finish;

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_pos    = r_pos;
        n_strobe = 1'b0;
        n_out    = '0;
        finish   = 1'b0;
        o_pop    = 1'b0;
        case (r_state)
            S_IDLE: ;
            S_DIGIT: begin
                n_strobe        = 1'b1;
                n_out.char_code = ASC_ZERO | {4'd0, r_job.digits[r_pos]};
                if (r_job.has_pnt && (r_pos == r_job.pnt_pos)) begin
                    n_state = S_POINT;
                    n_pos   = r_pos - 4'd1;
                end else if (r_pos == r_job.stop) begin
                    if (r_job.has_unit) begin
                        n_state = S_UNIT;
                    end else begin
                        n_out.last = 1'b1;
                        finish     = 1'b1;
                    end
                end else begin
                    n_pos = r_pos - 4'd1;
                end
            end
            S_POINT: begin
                n_strobe        = 1'b1;
                n_out.char_code = ASC_POINT;
                n_state         = S_DIGIT;
            end
            S_UNIT: begin
                n_strobe        = 1'b1;
                n_out.char_code = r_job.unit_ch;
                n_out.last      = 1'b1;
                finish          = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
        // next job starts straight after the last character
        if ((r_state == S_IDLE) || finish) begin
            if (!i_q_stat.empty) begin
                o_pop   = 1'b1;
                n_job   = i_job;
                n_pos   = i_job.top;
                n_state = S_DIGIT;
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_pos <= n_pos;
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// File: sv/decimal_si_prefix_formatter.sv
// ============================================================================
// decimal_si_prefix_formatter - unsigned value to engineering-notation ASCII
// Prints a 32-bit value as digits, optional point and fraction, and an SI
// prefix letter where one applies, one character per output beat.
// ============================================================================
// Usage:
//   Input: drive i_item and raise start; the beat is taken on a rising edge
//   with start high and busy low. busy drops again once the converter can
//   take a further number, normally while earlier numbers are still being
//   printed.
//   Output: o_strobe marks each character on o_result for one cycle; the
//   final character of a number carries last. The receiver cannot stall, so
//   characters leave at one per cycle with no gaps inside a number.
//   Path: double-dabble conversion (four bits per cycle), then classify and
//   queue push, then sequencer load, then the output register, after which
//   the first character appears. A full queue holds the push.
//   The converter's eight steps plus its queue push are spent on each number,
//   and it takes the next one in its push state; a number is 1..12 characters.
//   A two-entry job queue sits between converter and sequencer so that a
//   long number being printed does not hold up conversion of the next.
//   Zero prints '0'. Below 1000 only the digits are sent.
//   Reset (synchronous, i_rst_n low) empties the queue and idles both
//   halves; no output strobe is raised until a new beat arrives.
// ============================================================================
module decimal_si_prefix_formatter
    import sipf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_beat  i_item,
    output logic      o_strobe,
    output t_out_beat o_result
);

    t_job    push_job, head_job;
    logic    push, pop;
    t_q_stat q_stat;

    // converter and classifier
    sipf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    // decoupling queue
    sipf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    // character sequencer with registered output beat
    sipf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
